// File: design/knn_pkg.sv
// ============================================================================
// knn_pkg : shared types and constants for the k-nearest-neighbor block
// Field widths, register indexes, action codes and inter-module structs.
// ============================================================================
`default_nettype none

package knn_pkg;

  // fixed field widths
  localparam int DIST_W    = 38;
  localparam int ID_W      = 17;
  localparam int CAND_ID_W = 16;
  localparam int RANK_W    = 4;
  localparam int ACT_W     = 2;

  // configuration registers
  localparam int KREG_W    = 5;
  localparam int DREG_W    = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_K_IN_USE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 1'b1;

  localparam logic [KREG_W-1:0] K_RESET    = 5'd16;
  localparam logic [DREG_W-1:0] DIMS_RESET = 7'd8;

  // parameter defaults
  localparam int DEF_MAX_K      = 16;
  localparam int DEF_MAX_DIMS   = 64;
  localparam int DEF_COORD_BITS = 16;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [ID_W-1:0]   id_t;

  localparam dist_t DIST_ONES = '1;
  localparam id_t   ID_EMPTY  = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_QUERY = 2'd0,
    ACT_CAND  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef struct packed {
    dist_t distance;
    id_t   id;
  } entry_t;

  // distance unit -> sequencer
  typedef struct packed {
    logic  valid;   // one candidate coordinate finished
    logic  insert;  // point complete and not excluded
    dist_t distance;
    id_t   id;
  } dist_res_t;

  // sequencer -> list
  typedef struct packed {
    logic  ins;
    logic  rd;
    logic  clr;
    dist_t distance;
    id_t   id;
  } list_cmd_t;

endpackage

`default_nettype wire

// File: design/knn_sorted_topk_distance.sv
// ============================================================================
// knn_sorted_topk_distance : brute-force k-nearest-neighbor search
// Squared Euclidean distance of streamed candidates against a stored query,
// kept in a sorted top-k list of (distance, id).
// ============================================================================
// Items are taken one at a time; in_ready_o drops while an item is in work.
// A query coordinate or a clear is taken without leaving the idle state. A
// candidate coordinate passes through a registered read of the query store,
// one COORD_BITS x COORD_BITS multiply and one saturating 38-bit add. On the
// last coordinate of a point that is not excluded, the list insertion
// follows: a single comparator walks the list from the tail, moving one
// entry down per cycle through the list store (one write and one read port).
// A read passes each entry through the registered store read, then the
// output register, and holds it while out_ready_i stays low. Entries come out
// in rank order with last_o on the final one. Distances saturate at all ones;
// an empty slot reads as all-ones distance and id -1. Clear takes effect at
// once (per-slot valid bits), so there is no clearing pass after reset.
// ============================================================================
`default_nettype none

module knn_sorted_topk_distance #(
  parameter int MAX_K      = knn_pkg::DEF_MAX_K,
  parameter int MAX_DIMS   = knn_pkg::DEF_MAX_DIMS,
  parameter int COORD_BITS = knn_pkg::DEF_COORD_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [knn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [knn_pkg::CFG_W-1:0]      cfg_data_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [knn_pkg::ACT_W-1:0]      action_i,
  input  logic [COORD_BITS-1:0]          coordinate_i,
  input  logic [knn_pkg::CAND_ID_W-1:0]  candidate_id_i,
  input  logic                           exclude_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [knn_pkg::RANK_W-1:0]     rank_o,
  output knn_pkg::dist_t                 neighbor_distance_o,
  output knn_pkg::id_t                   neighbor_id_o,
  output logic                           last_o
);
  import knn_pkg::*;

  localparam int KIDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  // top sequencer: idle, waiting on the distance unit, waiting on the list
  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_DIST = 3'b010,
    T_LIST = 3'b100
  } tstate_e;

  tstate_e st_q, st_d;

  logic [KREG_W-1:0] k_in_use_q;
  logic [DREG_W-1:0] dims_in_use_q;
  logic [KIDX_W-1:0] last_idx;
  logic [DREG_W-1:0] dims_eff;

  logic      in_fire;
  action_e   act;
  logic      q_we, c_go;
  dist_res_t dres;
  list_cmd_t lcmd;
  logic      lst_busy;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_in_use_q    <= K_RESET;
      dims_in_use_q <= DIMS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_K_IN_USE:    k_in_use_q    <= cfg_data_i[KREG_W-1:0];
        REG_DIMS_IN_USE: dims_in_use_q <= cfg_data_i[DREG_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, anything above the build maximum acts as the maximum.
  always_comb begin
    if (k_in_use_q == '0) begin
      last_idx = '0;
    end else if (int'(k_in_use_q) > MAX_K) begin
      last_idx = KIDX_W'(MAX_K - 1);
    end else begin
      last_idx = KIDX_W'(k_in_use_q - KREG_W'(1));
    end
    if (dims_in_use_q == '0) begin
      dims_eff = DREG_W'(1);
    end else if (int'(dims_in_use_q) > MAX_DIMS) begin
      dims_eff = DREG_W'(MAX_DIMS);
    end else begin
      dims_eff = dims_in_use_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Item sequencer
  // ---------------------------------------------------------------------------
  assign in_ready_o = (st_q == T_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign act        = action_e'(action_i);

  always_comb begin
    st_d          = st_q;
    q_we          = 1'b0;
    c_go          = 1'b0;
    lcmd.ins      = 1'b0;
    lcmd.rd       = 1'b0;
    lcmd.clr      = 1'b0;
    lcmd.distance = dres.distance;
    lcmd.id       = dres.id;
    case (st_q)
      T_IDLE: begin
        if (in_fire) begin
          case (act)
            ACT_QUERY: q_we = 1'b1;
            ACT_CAND: begin
              c_go = 1'b1;
              st_d = T_DIST;
            end
            ACT_CLEAR: lcmd.clr = 1'b1;
            ACT_READ: begin
              lcmd.rd = 1'b1;
              st_d    = T_LIST;
            end
            default: ;
          endcase
        end
      end
      T_DIST: begin
        if (dres.valid) begin
          if (dres.insert) begin
            lcmd.ins = 1'b1;
            st_d     = T_LIST;
          end else begin
            st_d = T_IDLE;
          end
        end
      end
      T_LIST: begin
        if (!lst_busy) begin
          st_d = T_IDLE;
        end
      end
      default: begin
        st_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= T_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  knn_dist_unit #(
    .MAX_DIMS   (MAX_DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_we_i       (q_we),
    .c_go_i       (c_go),
    .coordinate_i (coordinate_i),
    .cand_id_i    (candidate_id_i),
    .exclude_i    (exclude_i),
    .dims_i       (dims_eff),
    .res_o        (dres)
  );

  knn_topk_list #(
    .MAX_K (MAX_K)
  ) u_list (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (lcmd),
    .last_idx_i          (last_idx),
    .busy_o              (lst_busy),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .rank_o              (rank_o),
    .neighbor_distance_o (neighbor_distance_o),
    .neighbor_id_o       (neighbor_id_o),
    .last_o              (last_o)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_ins_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcmd.ins |-> !lst_busy)
    else $error("list insert issued while list busy");

  a_out_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("result pending while accepting items");

  a_dist_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dres.valid |-> (st_q == T_DIST))
    else $error("distance result outside wait state");

  a_read_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && act == ACT_READ) |=> (!in_ready_o && lst_busy))
    else $error("read item did not start list readout");

endmodule

`default_nettype wire

// File: design/knn_dist_unit.sv
// ============================================================================
// knn_dist_unit : query store and squared-distance accumulator
// Holds the query point, squares one coordinate difference per pass and
// sums into a saturating distance accumulator.
// ============================================================================
`default_nettype none

module knn_dist_unit #(
  parameter int MAX_DIMS   = knn_pkg::DEF_MAX_DIMS,
  parameter int COORD_BITS = knn_pkg::DEF_COORD_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_we_i,
  input  logic                           c_go_i,
  input  logic [COORD_BITS-1:0]          coordinate_i,
  input  logic [knn_pkg::CAND_ID_W-1:0]  cand_id_i,
  input  logic                           exclude_i,
  input  logic [knn_pkg::DREG_W-1:0]     dims_i,
  output knn_pkg::dist_res_t             res_o
);
  import knn_pkg::*;

  localparam int QIDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;

  logic [COORD_BITS-1:0] qmem [MAX_DIMS];
  logic [COORD_BITS-1:0] qrd_q;
  logic [COORD_BITS-1:0] cand_q;
  logic [CAND_ID_W-1:0]  id_q;
  logic                  excl_q;
  logic [SQ_W-1:0]       sq_q;
  logic                  mul_q, add_q;

  logic [DREG_W-1:0] qcnt_q, qcnt_d, ccnt_q, ccnt_d;
  logic [DREG_W-1:0] qcnt_inc, ccnt_inc;
  dist_t             acc_q, acc_d;

  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS:0]        mag_full;
  logic [COORD_BITS-1:0]      mag;
  logic [SUM_W-1:0]           sum;
  dist_t                      sat;
  logic                       pt_end;

  // |diff| never exceeds 2^COORD_BITS - 1
  assign diff     = $signed({cand_q[COORD_BITS-1], cand_q})
                  - $signed({qrd_q[COORD_BITS-1], qrd_q});
  assign mag_full = diff[COORD_BITS] ? unsigned'(-diff) : unsigned'(diff);
  assign mag      = mag_full[COORD_BITS-1:0];

  assign sum      = SUM_W'(sq_q) + SUM_W'(acc_q);
  assign sat      = (sum > SUM_W'(DIST_ONES)) ? DIST_ONES : sum[DIST_W-1:0];

  assign qcnt_inc = qcnt_q + DREG_W'(1);
  assign ccnt_inc = ccnt_q + DREG_W'(1);
  assign pt_end   = (ccnt_inc >= dims_i);

  always_comb begin
    qcnt_d = qcnt_q;
    ccnt_d = ccnt_q;
    acc_d  = acc_q;
    if (q_we_i) begin
      qcnt_d = (qcnt_inc >= dims_i) ? '0 : qcnt_inc;
    end
    if (add_q) begin
      if (pt_end) begin
        ccnt_d = '0;
        acc_d  = '0;
      end else begin
        ccnt_d = ccnt_inc;
        acc_d  = sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcnt_q <= '0;
      ccnt_q <= '0;
      acc_q  <= '0;
      mul_q  <= 1'b0;
      add_q  <= 1'b0;
    end else begin
      qcnt_q <= qcnt_d;
      ccnt_q <= ccnt_d;
      acc_q  <= acc_d;
      mul_q  <= c_go_i;
      add_q  <= mul_q;
    end
  end

  // query store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (q_we_i) begin
      qmem[qcnt_q[QIDX_W-1:0]] <= coordinate_i;
    end
    qrd_q <= qmem[ccnt_q[QIDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (c_go_i) begin
      cand_q <= coordinate_i;
      id_q   <= cand_id_i;
      excl_q <= exclude_i;
    end
    if (mul_q) begin
      sq_q <= SQ_W'(mag) * SQ_W'(mag);
    end
  end

  assign res_o.valid    = add_q;
  assign res_o.insert   = add_q & pt_end & ~excl_q;
  assign res_o.distance = sat;
  assign res_o.id       = ID_W'(id_q);

endmodule

`default_nettype wire

// File: design/knn_topk_list.sv
// ============================================================================
// knn_topk_list : sorted neighbor list with one shared comparator
// Insertion walks from the tail, shifting larger entries down one slot per
// cycle; reads stream entries out in rank order.
// ============================================================================
`default_nettype none

module knn_topk_list #(
  parameter int MAX_K = knn_pkg::DEF_MAX_K,
  localparam int KIDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  knn_pkg::list_cmd_t          cmd_i,
  input  logic [KIDX_W-1:0]           last_idx_i,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [knn_pkg::RANK_W-1:0]  rank_o,
  output knn_pkg::dist_t              neighbor_distance_o,
  output knn_pkg::id_t                neighbor_id_o,
  output logic                        last_o
);
  import knn_pkg::*;

  typedef enum logic [5:0] {
    L_IDLE  = 6'b000001,
    L_CHK   = 6'b000010,
    L_STEP  = 6'b000100,
    L_PUT   = 6'b001000,
    L_RWAIT = 6'b010000,
    L_OUT   = 6'b100000
  } lstate_e;

  localparam entry_t EMPTY_ENT = '{distance: DIST_ONES, id: ID_EMPTY};

  lstate_e st_q, st_d;

  entry_t            mem [MAX_K];
  entry_t            rdat_q;
  logic              rvld_q;
  logic [MAX_K-1:0]  vld_q, vld_d;

  logic [KIDX_W-1:0] idx_q, idx_d, raddr, idx_dec, idx_dec2, idx_inc;
  logic              we;
  entry_t            wdat, rent, new_ent;
  dist_t             d_q;
  id_t               id_q;
  logic              lt;
  logic              ov_q, ov_d, ld_out;

  logic [RANK_W-1:0] rank_q;
  dist_t             odist_q;
  id_t               oid_q;
  logic              olast_q;

  // slot never written since the last clear reads as empty
  assign rent     = rvld_q ? rdat_q : EMPTY_ENT;
  assign new_ent  = '{distance: d_q, id: id_q};
  assign lt       = (d_q < rent.distance);   // the shared comparator
  assign idx_dec  = idx_q - KIDX_W'(1);
  assign idx_dec2 = idx_q - KIDX_W'(2);
  assign idx_inc  = idx_q + KIDX_W'(1);

  always_comb begin
    st_d   = st_q;
    idx_d  = idx_q;
    raddr  = idx_q;
    we     = 1'b0;
    wdat   = new_ent;
    vld_d  = vld_q;
    ov_d   = ov_q;
    ld_out = 1'b0;
    case (st_q)
      L_IDLE: begin
        if (cmd_i.clr) begin
          vld_d = '0;
        end
        if (cmd_i.ins) begin
          raddr = last_idx_i;
          idx_d = last_idx_i;
          st_d  = L_CHK;
        end else if (cmd_i.rd) begin
          raddr = '0;
          idx_d = '0;
          st_d  = L_RWAIT;
        end
      end
      L_CHK: begin
        if (!lt) begin
          st_d = L_IDLE;
        end else if (idx_q == '0) begin
          we   = 1'b1;
          st_d = L_IDLE;
        end else begin
          raddr = idx_dec;
          st_d  = L_STEP;
        end
      end
      L_STEP: begin
        we = 1'b1;
        if (lt) begin
          wdat  = rent;
          idx_d = idx_dec;
          if (idx_dec == '0) begin
            st_d = L_PUT;
          end else begin
            raddr = idx_dec2;
          end
        end else begin
          st_d = L_IDLE;
        end
      end
      L_PUT: begin
        we   = 1'b1;
        st_d = L_IDLE;
      end
      L_RWAIT: begin
        ld_out = 1'b1;
        ov_d   = 1'b1;
        st_d   = L_OUT;
      end
      L_OUT: begin
        if (out_ready_i) begin
          ov_d = 1'b0;
          if (idx_q == last_idx_i) begin
            st_d = L_IDLE;
          end else begin
            idx_d = idx_inc;
            raddr = idx_inc;
            st_d  = L_RWAIT;
          end
        end
      end
      default: begin
        st_d = L_IDLE;
      end
    endcase
    if (we) begin
      vld_d[idx_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= L_IDLE;
      vld_q  <= '0;
      ov_q   <= 1'b0;
      idx_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      vld_q  <= vld_d;
      ov_q   <= ov_d;
      idx_q  <= idx_d;
      rvld_q <= vld_q[raddr];
    end
  end

  // list store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q] <= wdat;
    end
    rdat_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == L_IDLE && cmd_i.ins) begin
      d_q  <= cmd_i.distance;
      id_q <= cmd_i.id;
    end
    if (ld_out) begin
      rank_q  <= RANK_W'(idx_q);
      odist_q <= rent.distance;
      oid_q   <= rent.id;
      olast_q <= (idx_q == last_idx_i);
    end
  end

  assign busy_o              = (st_q != L_IDLE);
  assign out_valid_o         = ov_q;
  assign rank_o              = rank_q;
  assign neighbor_distance_o = odist_q;
  assign neighbor_id_o       = oid_q;
  assign last_o              = olast_q;

endmodule

`default_nettype wire
